/* rtl/addressed_packet_receiver_core_defines.svh */
// Assertion macros shared by the receiver modules.
`ifndef ADDRESSED_PACKET_RECEIVER_CORE_DEFINES_SVH
`define ADDRESSED_PACKET_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check an implication property on every clock edge outside reset.
`define APR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Check that a condition never holds outside reset.
`define APR_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define APR_ASSERT(lbl, clk, rstn, prop)
`define APR_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

/* rtl/apr_pkg.sv */
// Types, codes and the CRC helper shared by the packet receiver modules.
package apr_pkg;

  localparam logic [3:0]  BROADCAST_ADDR = 4'hF;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_STATUS  = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;

  // Frame positions, counted from the address character as one
  localparam logic [6:0] POS_CTRL  = 7'd2;
  localparam logic [6:0] POS_CHECK = 7'd3;
  localparam logic [6:0] POS_MAX   = 7'd68;

  // One classified character handed from the front end to the back end
  typedef struct packed {
    logic        has_payload;
    logic [7:0]  payload;
    logic        has_end;
    logic        crc_ok;
    logic        send_ack;
    logic [3:0]  own_addr;
    logic [7:0]  hdr_addr;
    logic [7:0]  hdr_ctrl;
    logic [15:0] tail_bytes;
  } job_t;

  // Result sequencer steps
  typedef enum logic [2:0] {
    STEP_PAYLOAD,
    STEP_STATUS,
    STEP_ACK0,
    STEP_ACK1,
    STEP_ACK2,
    STEP_CRC_HI,
    STEP_CRC_LO
  } step_e;

  // CRC-16/CCITT-FALSE update by one byte, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/apr_front.sv */
// Front end: frame tracking, header check, CRC and classification of each character.
`include "addressed_packet_receiver_core_defines.svh"

module apr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [3:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            addr_bit_i,
  input  logic [7:0]      rx_byte_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output apr_pkg::job_t   job_o
);

  logic [3:0]  own_addr_q;
  logic        receiving_q, receiving_d;
  logic [6:0]  byte_count_q, byte_count_d;
  logic [6:0]  expected_tail_q, expected_tail_d;
  logic [7:0]  header_addr_q, header_addr_d;
  logic [7:0]  header_ctrl_q, header_ctrl_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] last_two_q, last_two_d;

  logic        in_fire;
  logic [6:0]  cnt;
  logic [5:0]  len;
  logic        addr_match;
  logic        dropped;
  logic        has_payload;
  logic        has_end;

  assign in_ready_o = job_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Hold the node address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= 4'd0;
    end else if (cfg_we_i) begin
      own_addr_q <= cfg_wdata_i;
    end
  end

  // Advance frame state per accepted request
  always_comb begin
    receiving_d     = receiving_q;
    byte_count_d    = byte_count_q;
    expected_tail_d = expected_tail_q;
    header_addr_d   = header_addr_q;
    header_ctrl_d   = header_ctrl_q;
    crc_d           = crc_q;
    last_two_d      = last_two_q;
    dropped         = 1'b0;
    has_payload     = 1'b0;
    has_end         = 1'b0;
    cnt             = byte_count_q + 7'd1;
    len             = header_ctrl_q[5:0];
    addr_match      = (rx_byte_i[3:0] == own_addr_q) ||
                      (rx_byte_i[3:0] == apr_pkg::BROADCAST_ADDR);
    if (in_fire) begin
      if (addr_bit_i) begin
        if (receiving_q) begin
          // an address character mid-frame drops the frame
          receiving_d = 1'b0;
        end else if (addr_match) begin
          receiving_d     = 1'b1;
          byte_count_d    = 7'd1;
          expected_tail_d = 7'd0;
          header_addr_d   = rx_byte_i;
          header_ctrl_d   = 8'd0;
          crc_d           = apr_pkg::CRC_INIT;
          last_two_d      = 16'd0;
        end
      end else if (receiving_q) begin
        byte_count_d = cnt;
        if (cnt == apr_pkg::POS_CTRL) begin
          header_ctrl_d   = rx_byte_i;
          expected_tail_d = rx_byte_i[6] ? 7'd0 : ({1'b0, rx_byte_i[5:0]} + 7'd2);
        end else if (cnt == apr_pkg::POS_CHECK) begin
          if ((header_addr_q ^ header_ctrl_q) != rx_byte_i) begin
            receiving_d = 1'b0;
            dropped     = 1'b1;
          end
        end else begin
          if (cnt <= (apr_pkg::POS_CHECK + {1'b0, len})) begin
            has_payload = 1'b1;
            crc_d       = apr_pkg::crc_feed(crc_q, rx_byte_i);
          end
          last_two_d = {last_two_q[7:0], rx_byte_i};
        end
        if (!dropped && (cnt == apr_pkg::POS_CHECK + expected_tail_q)) begin
          receiving_d = 1'b0;
          has_end     = 1'b1;
        end
      end
    end
  end

  // Build the job; the end character never carries payload, so crc_q is final
  always_comb begin
    job_o.has_payload = has_payload;
    job_o.payload     = rx_byte_i;
    job_o.has_end     = has_end;
    job_o.crc_ok      = header_ctrl_q[6] || (len == 6'd0) || (crc_q == last_two_d);
    job_o.send_ack    = has_end && header_ctrl_q[7] && (len != 6'd0);
    job_o.own_addr    = own_addr_q;
    job_o.hdr_addr    = header_addr_q;
    job_o.hdr_ctrl    = header_ctrl_q;
    job_o.tail_bytes  = last_two_d;
  end

  assign job_valid_o = in_fire && (has_payload || has_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q     <= 1'b0;
      byte_count_q    <= 7'd0;
      expected_tail_q <= 7'd0;
      header_addr_q   <= 8'd0;
      header_ctrl_q   <= 8'd0;
      crc_q           <= apr_pkg::CRC_INIT;
      last_two_q      <= 16'd0;
    end else begin
      receiving_q     <= receiving_d;
      byte_count_q    <= byte_count_d;
      expected_tail_q <= expected_tail_d;
      header_addr_q   <= header_addr_d;
      header_ctrl_q   <= header_ctrl_d;
      crc_q           <= crc_d;
      last_two_q      <= last_two_d;
    end
  end

  // A frame never runs past header, 63 payload bytes and two CRC bytes
  `APR_ASSERT(a_count_bound, clk_i, rst_ni, receiving_q |-> byte_count_q <= apr_pkg::POS_MAX)
  // An ack is only ever requested together with a frame end
  `APR_ASSERT(a_ack_needs_end, clk_i, rst_ni, job_valid_o && job_o.send_ack |-> job_o.has_end)
  // A payload byte and a frame end never come from the same character
  `APR_ASSERT_NEVER(a_payload_end, clk_i, rst_ni, job_o.has_payload && job_o.has_end)

endmodule

/* rtl/apr_queue.sv */
// Two-entry job queue between the front end and the back end.
module apr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  apr_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output apr_pkg::job_t pop_job_o
);

  apr_pkg::job_t mem_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;
  logic          push;
  logic          pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  // Write entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/apr_back.sv */
// Back end: expands each job into its result requests and holds the output register.
`include "addressed_packet_receiver_core_defines.svh"

module apr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_pop_o,
  input  apr_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [7:0]    out_byte_o,
  output logic [3:0]    src_address_o,
  output logic          is_command_o,
  output logic          ack_requested_o,
  output logic [5:0]    length_field_o,
  output logic          crc_ok_o,
  output logic          last_o
);

  apr_pkg::step_e step_q, step_d, cur_step;
  logic           active_q, active_d;
  logic           emit;
  logic           step_last;
  logic [1:0]     res_kind;
  logic [7:0]     res_byte;
  logic           res_ok;
  logic [7:0]     ack0;
  logic [7:0]     ack1;

  logic           out_valid_q;
  logic [1:0]     kind_q;
  logic [7:0]     byte_q;
  logic [3:0]     src_q;
  logic           cmd_q;
  logic           ackreq_q;
  logic [5:0]     len_q;
  logic           ok_q;
  logic           last_q;

  assign emit      = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_pop_o = emit && step_last;
  assign ack0      = {job_i.own_addr, job_i.hdr_addr[7:4]};
  assign ack1      = {1'b1, job_i.hdr_ctrl[6], 6'd0};

  // Pick the current step, the result it makes and the next step
  always_comb begin
    cur_step  = active_q ? step_q : (job_i.has_payload ? apr_pkg::STEP_PAYLOAD
                                                       : apr_pkg::STEP_STATUS);
    step_d    = step_q;
    active_d  = active_q;
    step_last = 1'b1;
    res_kind  = apr_pkg::KIND_ACK;
    res_byte  = 8'd0;
    res_ok    = 1'b0;
    unique case (cur_step)
      apr_pkg::STEP_PAYLOAD: begin
        res_kind  = apr_pkg::KIND_PAYLOAD;
        res_byte  = job_i.payload;
        step_last = !job_i.has_end;
        step_d    = apr_pkg::STEP_STATUS;
      end
      apr_pkg::STEP_STATUS: begin
        res_kind  = apr_pkg::KIND_STATUS;
        res_ok    = job_i.crc_ok;
        step_last = !job_i.send_ack;
        step_d    = apr_pkg::STEP_ACK0;
      end
      apr_pkg::STEP_ACK0: begin
        res_byte  = ack0;
        step_last = 1'b0;
        step_d    = apr_pkg::STEP_ACK1;
      end
      apr_pkg::STEP_ACK1: begin
        res_byte  = ack1;
        step_last = 1'b0;
        step_d    = apr_pkg::STEP_ACK2;
      end
      apr_pkg::STEP_ACK2: begin
        res_byte  = ack0 ^ ack1;
        step_last = job_i.hdr_ctrl[6];
        step_d    = apr_pkg::STEP_CRC_HI;
      end
      apr_pkg::STEP_CRC_HI: begin
        res_byte  = job_i.tail_bytes[15:8];
        step_last = 1'b0;
        step_d    = apr_pkg::STEP_CRC_LO;
      end
      apr_pkg::STEP_CRC_LO: begin
        res_byte  = job_i.tail_bytes[7:0];
        step_last = 1'b1;
        step_d    = apr_pkg::STEP_CRC_LO;
      end
      default: begin
        step_last = 1'b1;
      end
    endcase
    if (emit) begin
      active_d = !step_last;
    end else begin
      step_d = step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= apr_pkg::STEP_PAYLOAD;
      active_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      active_q <= active_d;
    end
  end

  // Hold the result until taken, load the next one behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q   <= res_kind;
      byte_q   <= res_byte;
      src_q    <= job_i.hdr_addr[7:4];
      cmd_q    <= job_i.hdr_ctrl[6];
      ackreq_q <= job_i.hdr_ctrl[7];
      len_q    <= job_i.hdr_ctrl[5:0];
      ok_q     <= res_ok;
      last_q   <= step_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign out_byte_o      = byte_q;
  assign src_address_o   = src_q;
  assign is_command_o    = cmd_q;
  assign ack_requested_o = ackreq_q;
  assign length_field_o  = len_q;
  assign crc_ok_o        = ok_q;
  assign last_o          = last_q;

  // A job stays at the queue head until its last result is loaded into the output register
  `APR_ASSERT(a_active_has_job, clk_i, rst_ni, active_q |-> job_valid_i)
  // CRC bytes of an ack only follow a data frame
  `APR_ASSERT(a_crc_data_only, clk_i, rst_ni,
              active_q && step_q == apr_pkg::STEP_CRC_HI |-> !job_i.hdr_ctrl[6])
  // Only a status result carries a CRC verdict
  `APR_ASSERT(a_ok_status_only, clk_i, rst_ni,
              out_valid_o && kind_o != apr_pkg::KIND_STATUS |-> !crc_ok_o)

endmodule

/* rtl/addressed_packet_receiver_core.sv */
// Top level of the addressed 9-bit multidrop packet receiver.

// Receives 9-bit multidrop characters, opens a frame on an address character for
// this node or broadcast, checks the header, streams payload bytes, runs
// CRC-16/CCITT-FALSE and at frame end issues a status result and, when asked
// with a nonzero length, the ack frame bytes. The front end takes one character
// a cycle while its two-entry job queue has room; the back end's sequencer sends
// one result a cycle from the output register while that register is empty or
// being taken. A payload character makes one result; a frame end makes one for
// status, four with a command ack, six with a data ack. A result passes through
// the job queue and the output register. There is no clearing pass after reset.
module addressed_packet_receiver_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       addr_bit_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [3:0] src_address_o,
  output logic       is_command_o,
  output logic       ack_requested_o,
  output logic [5:0] length_field_o,
  output logic       crc_ok_o,
  output logic       last_o
);

  apr_pkg::job_t front_job;
  apr_pkg::job_t head_job;
  logic          front_valid;
  logic          front_ready;
  logic          head_valid;
  logic          head_pop;

  apr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .addr_bit_i  (addr_bit_i),
    .rx_byte_i   (rx_byte_i),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  apr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_job_i   (front_job),
    .pop_valid_o  (head_valid),
    .pop_i        (head_pop),
    .pop_job_o    (head_job)
  );

  apr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (head_valid),
    .job_pop_o       (head_pop),
    .job_i           (head_job),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .out_byte_o      (out_byte_o),
    .src_address_o   (src_address_o),
    .is_command_o    (is_command_o),
    .ack_requested_o (ack_requested_o),
    .length_field_o  (length_field_o),
    .crc_ok_o        (crc_ok_o),
    .last_o          (last_o)
  );

endmodule

/* bench/addressed_packet_receiver_core_tb.sv */
// Self-checking bench for the addressed packet receiver core with bursty traffic and stalls.
module addressed_packet_receiver_core_tb;

  typedef struct packed {
    logic       abit;
    logic [7:0] data;
  } rx_char_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] src;
    logic       cmd;
    logic       ack_req;
    logic [5:0] len;
    logic       crc_good;
    logic       last;
  } rx_result_t;

  localparam int LATENCY_WAIT = 20;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [3:0] cfg_wdata_i = 4'd0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic       addr_bit_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic [3:0] src_address_o;
  logic       is_command_o;
  logic       ack_requested_o;
  logic [5:0] length_field_o;
  logic       crc_ok_o;
  logic       last_o;

  addressed_packet_receiver_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .addr_bit_i      (addr_bit_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .out_byte_o      (out_byte_o),
    .src_address_o   (src_address_o),
    .is_command_o    (is_command_o),
    .ack_requested_o (ack_requested_o),
    .length_field_o  (length_field_o),
    .crc_ok_o        (crc_ok_o),
    .last_o          (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Characters waiting to be sent and results still owed by the block
  rx_char_t   char_queue[$];
  rx_result_t due_results[$];
  int         chars_queued   = 0;
  int         chars_accepted = 0;
  int         mismatches     = 0;

  // Frame decoder state, mirrored from the block
  logic [3:0]  node_addr = 4'd0;
  logic        fr_open   = 1'b0;
  logic [6:0]  fr_pos    = 7'd0;
  logic [6:0]  fr_end    = 7'd0;
  logic [7:0]  fr_addr   = 8'd0;
  logic [7:0]  fr_ctrl   = 8'd0;
  logic [15:0] fr_crc    = 16'hFFFF;
  logic [15:0] fr_tail   = 16'd0;

  // CRC-16/CCITT-FALSE, one message bit at a time
  function automatic logic [15:0] crc_xmodem_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ 16'h1021;
      end
    end
    return c;
  endfunction

  function automatic rx_result_t frame_result(logic [1:0] k, logic [7:0] d, logic good);
    rx_result_t r;
    r.kind     = k;
    r.data     = d;
    r.src      = fr_addr[7:4];
    r.cmd      = fr_ctrl[6];
    r.ack_req  = fr_ctrl[7];
    r.len      = fr_ctrl[5:0];
    r.crc_good = good;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic string show(rx_result_t r);
    return $sformatf("kind=%0d byte=%02h src=%0h cmd=%0b ack=%0b len=%0d crc_ok=%0b last=%0b",
                     r.kind, r.data, r.src, r.cmd, r.ack_req, r.len, r.crc_good, r.last);
  endfunction

  // Advance the frame decoder by one character and queue the results it owes
  task automatic decode_char(rx_char_t ch);
    rx_result_t res[$];
    int         flen;
    logic       good;
    logic [7:0] a0;
    logic [7:0] a1;
    if (ch.abit) begin
      if (fr_open) begin
        fr_open = 1'b0;
      end else if (ch.data[3:0] == node_addr || ch.data[3:0] == 4'hF) begin
        fr_open = 1'b1;
        fr_pos  = 7'd1;
        fr_end  = 7'd3;
        fr_addr = ch.data;
        fr_ctrl = 8'd0;
        fr_crc  = 16'hFFFF;
        fr_tail = 16'd0;
      end
      return;
    end
    if (!fr_open) return;
    fr_pos = fr_pos + 7'd1;
    flen   = fr_ctrl[5:0];
    if (fr_pos == 7'd2) begin
      fr_ctrl = ch.data;
      flen    = ch.data[5:0];
      fr_end  = ch.data[6] ? 7'd3 : 7'(flen + 5);
    end else if (fr_pos == 7'd3) begin
      if ((fr_addr ^ fr_ctrl) != ch.data) begin
        fr_open = 1'b0;
        return;
      end
    end else begin
      if (fr_pos <= 3 + flen) begin
        res.push_back(frame_result(apr_pkg::KIND_PAYLOAD, ch.data, 1'b0));
        fr_crc = crc_xmodem_byte(fr_crc, ch.data);
      end
      fr_tail = {fr_tail[7:0], ch.data};
    end
    // Close the frame: status, then the ack frame if one was asked for and the length is not zero
    if (fr_pos == fr_end) begin
      fr_open = 1'b0;
      good    = fr_ctrl[6] || flen == 0 || fr_crc == fr_tail;
      res.push_back(frame_result(apr_pkg::KIND_STATUS, 8'd0, good));
      if (fr_ctrl[7] && flen != 0) begin
        a0 = {node_addr, fr_addr[7:4]};
        a1 = {1'b1, fr_ctrl[6], 6'd0};
        res.push_back(frame_result(apr_pkg::KIND_ACK, a0, 1'b0));
        res.push_back(frame_result(apr_pkg::KIND_ACK, a1, 1'b0));
        res.push_back(frame_result(apr_pkg::KIND_ACK, a0 ^ a1, 1'b0));
        if (!fr_ctrl[6]) begin
          res.push_back(frame_result(apr_pkg::KIND_ACK, fr_tail[15:8], 1'b0));
          res.push_back(frame_result(apr_pkg::KIND_ACK, fr_tail[7:0], 1'b0));
        end
      end
    end
    foreach (res[i]) begin
      if (i == res.size() - 1) begin
        res[i].last = 1'b1;
      end
      due_results.push_back(res[i]);
    end
  endtask

  task automatic add_char(logic abit, logic [7:0] d);
    rx_char_t c;
    c.abit = abit;
    c.data = d;
    char_queue.push_back(c);
    chars_queued++;
  endtask

  function automatic logic [3:0] foreign_nibble();
    logic [3:0] n;
    do begin
      n = 4'($urandom_range(0, 14));
    end while (n == node_addr);
    return n;
  endfunction

  // Build one frame; optionally spoil the header check or CRC, or cut it short
  task automatic add_frame(logic [3:0] dest, logic cmd, logic ack, logic [5:0] len,
                           logic bad_xor, logic bad_crc, int cut);
    rx_char_t    f[$];
    logic [7:0]  a;
    logic [7:0]  c;
    logic [7:0]  x;
    logic [7:0]  d;
    logic [15:0] crc;
    a = {4'($urandom_range(0, 15)), dest};
    c = {ack, cmd, len};
    x = a ^ c;
    if (bad_xor) x = x ^ 8'(1 << $urandom_range(0, 7));
    f.push_back('{1'b1, a});
    f.push_back('{1'b0, c});
    f.push_back('{1'b0, x});
    if (!cmd) begin
      crc = 16'hFFFF;
      for (int i = 0; i < len; i++) begin
        d   = 8'($urandom);
        crc = crc_xmodem_byte(crc, d);
        f.push_back('{1'b0, d});
      end
      if (bad_crc) crc = crc ^ 16'(1 << $urandom_range(0, 15));
      f.push_back('{1'b0, crc[15:8]});
      f.push_back('{1'b0, crc[7:0]});
    end
    while (cut > 0 && f.size() > cut) void'(f.pop_back());
    foreach (f[i]) add_char(f[i].abit, f[i].data);
  endtask

  // Drop any open frame with an address for some other node
  task automatic close_frame();
    add_char(1'b1, {4'($urandom_range(0, 15)), foreign_nibble()});
  endtask

  // Hold until every request is taken and every result has come, then let the block settle
  task automatic wait_quiet();
    while (chars_accepted != chars_queued || due_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY_WAIT) @(posedge clk_i);
  endtask

  task automatic write_own_address(logic [3:0] own);
    wait_quiet();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= own;
    node_addr    = own;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic directed_frames();
    add_char(1'b0, 8'h00);
    add_char(1'b1, {4'h3, foreign_nibble()});
    add_frame(node_addr, 1'b0, 1'b1, 6'd1, 1'b0, 1'b0, 0);
    add_frame(node_addr, 1'b0, 1'b0, 6'd1, 1'b0, 1'b1, 0);
    add_frame(4'hF, 1'b1, 1'b1, 6'd63, 1'b0, 1'b0, 0);
    add_frame(node_addr, 1'b0, 1'b1, 6'd0, 1'b0, 1'b0, 0);
    add_frame(node_addr, 1'b0, 1'b0, 6'd2, 1'b1, 1'b0, 3);
    // A matching address mid-frame drops the frame and opens nothing
    add_frame(node_addr, 1'b0, 1'b1, 6'd4, 1'b0, 1'b0, 2);
    add_char(1'b1, {4'h2, node_addr});
    add_char(1'b0, 8'hFF);
  endtask

  task automatic random_frames(int target);
    int         counted;
    int         r;
    int         before_count;
    logic [3:0] dest;
    logic [5:0] len;
    counted = 0;
    while (counted < target) begin
      r            = $urandom_range(0, 99);
      dest         = ($urandom_range(0, 3) == 0) ? 4'hF : node_addr;
      before_count = chars_queued;
      case ($urandom_range(0, 19))
        0:       len = 6'd63;
        1:       len = 6'($urandom_range(0, 63));
        default: len = 6'($urandom_range(0, 6));
      endcase
      if (r < 70) begin
        add_frame(dest, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), len,
                  1'b0, $urandom_range(0, 5) == 0, 0);
      end else if (r < 82) begin
        add_frame(dest, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), len,
                  1'($urandom_range(0, 1)), 1'b0, $urandom_range(1, 4));
        close_frame();
      end else if (r < 90) begin
        add_frame(foreign_nibble(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), len,
                  1'b0, 1'b0, 0);
      end else begin
        repeat ($urandom_range(1, 3)) add_char(1'($urandom_range(0, 1)), 8'($urandom));
        close_frame();
      end
      if (r < 82) counted += chars_queued - before_count;
    end
    close_frame();
  endtask

  // Sender: bursts of random length separated by random gaps
  rx_char_t taken_char;
  rx_char_t next_char;
  int       burst_left = 1;
  int       gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        taken_char = {addr_bit_i, rx_byte_i};
        decode_char(taken_char);
        chars_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 || char_queue.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_char   = char_queue.pop_front();
          in_valid_i <= 1'b1;
          addr_bit_i <= next_char.abit;
          rx_byte_i  <= next_char.data;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Receiver: stall modes that change every so often, always-ready among them
  int         stall_mode = 0;
  int         mode_left  = 0;
  int         ready_tick = 0;
  rx_result_t seen_res;
  rx_result_t want_res;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen_res = {kind_o, out_byte_o, src_address_o, is_command_o, ack_requested_o,
                    length_field_o, crc_ok_o, last_o};
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", show(seen_res));
        end else begin
          want_res = due_results.pop_front();
          if (seen_res !== want_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch\n  expected %s\n  actual   %s",
                       show(want_res), show(seen_res));
            end
          end
        end
      end
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(50, 200);
      end
      mode_left--;
      ready_tick++;
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= (ready_tick % 4 == 0);
        default: out_ready_i <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Stimulus: directed frames, then random traffic under several node addresses
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_own_address(4'd5);
    directed_frames();
    write_own_address(4'd0);
    random_frames(80);
    write_own_address(4'd15);
    random_frames(80);
    repeat (3) begin
      write_own_address(4'($urandom_range(0, 15)));
      random_frames(80);
    end
    wait_quiet();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/apr_pkg.sv
rtl/apr_front.sv
rtl/apr_queue.sv
rtl/apr_back.sv
rtl/addressed_packet_receiver_core.sv
bench/addressed_packet_receiver_core_tb.sv
